// ===== hw/rtl/bmf_pkg.sv =====
// bmf_pkg: shared types, register codes and kernel helpers for the binary
// morphology filter. Used by every module of the block; depends on nothing.
`default_nettype none

package bmf_pkg;

    // geometry
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_KERNEL = 7;
    localparam int KC         = MAX_KERNEL / 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int IDX_W      = $clog2(MAX_KERNEL);
    localparam int LAG_W      = 2;
    localparam int PEND_W     = LAG_W + 1;
    localparam int ROW_CNT_W  = 16;

    // configuration port
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam int MASK_W = 49;

    localparam logic [2:0] REG_OPERATION     = 3'd0;
    localparam logic [2:0] REG_BACKGROUND    = 3'd1;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd2;
    localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd3;
    localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd4;
    localparam logic [2:0] REG_KERNEL_MASK   = 3'd5;

    localparam logic [1:0] OP_ERODE  = 2'd0;
    localparam logic [1:0] OP_DILATE = 2'd1;
    localparam logic [1:0] OP_OPEN   = 2'd2;
    localparam logic [1:0] OP_CLOSE  = 2'd3;

    // reset values of the registers
    localparam logic [6:0]        RST_IMAGE_WIDTH = 7'd64;
    localparam logic [2:0]        RST_KERNEL_DIM  = 3'd3;
    localparam logic [MASK_W-1:0] RST_KERNEL_MASK = MASK_W'(511);

    typedef logic [MAX_WIDTH-1:0]                  t_row;
    typedef logic [MAX_KERNEL-1:0][MAX_WIDTH-1:0]  t_lines;
    typedef logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0] t_taps;

    // window settings shared by both window units
    typedef struct packed {
        t_taps taps;
        t_row  keep;
        logic  dilate;
    } t_win_cfg;

    // line store status
    typedef struct packed {
        logic [IDX_W-1:0]  fill;
        logic [PEND_W-1:0] pend;
    } t_store_stat;

    // one result beat
    typedef struct packed {
        t_row                 pixels;
        logic [ROW_CNT_W-1:0] row;
        logic                 done;
    } t_result;

    // columns in use, clamped to the row word
    function automatic t_row width_mask(input logic [6:0] w);
        t_row m;
        if (w >= 7'(MAX_WIDTH)) begin
            m = '1;
        end else begin
            m = (t_row'(1) << w[COL_W-1:0]) - t_row'(1);
        end
        return m;
    endfunction

    // rows of the window below the center row
    function automatic logic [LAG_W-1:0] rows_below(input logic [2:0] kh);
        logic [2:0] r;
        if (kh == 3'd0) begin
            r = 3'd0;
        end else begin
            r = kh - 3'd1 - (kh >> 1);
        end
        return r[LAG_W-1:0];
    endfunction

    // kernel bits moved onto a fixed grid centered at (KC,KC)
    function automatic t_taps build_taps(input logic [2:0] kw, input logic [2:0] kh,
                                         input logic [MASK_W-1:0] mask);
        t_taps      t;
        int         ky;
        int         kx;
        logic [5:0] tap_idx;
        t = '0;
        for (int gy = 0; gy < MAX_KERNEL; gy++) begin
            for (int gx = 0; gx < MAX_KERNEL; gx++) begin
                ky = gy - KC + int'(kh >> 1);
                kx = gx - KC + int'(kw >> 1);
                tap_idx = 6'(ky * int'(kw) + kx);
                if (kw != 3'd0 && kh != 3'd0 && ky >= 0 && ky < int'(kh)
                        && kx >= 0 && kx < int'(kw)) begin
                    t[gy][gx] = mask[tap_idx];
                end
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bmf_lane.sv =====
// bmf_lane: one column lane, reduces the window neighborhood of one pixel.
// Depends on bmf_pkg for the tap grid type.
`default_nettype none

module bmf_lane import bmf_pkg::*; (
    input  t_taps i_nbhd,
    input  t_taps i_taps,
    input  logic  i_dilate,
    input  logic  i_keep,
    output logic  o_pix
);

    t_taps hit;
    t_taps pass;

    // any active tap hit, or every active tap foreground
    assign hit   = i_nbhd & i_taps;
    assign pass  = i_nbhd | ~i_taps;
    assign o_pix = i_keep & (i_dilate ? (|hit) : (&pass));

endmodule

`default_nettype wire

// ===== hw/rtl/bmf_window.sv =====
// bmf_window: picks the window rows out of a line store and runs one lane
// per column; the lane bits merge into the filtered row. Uses bmf_pkg, bmf_lane.
`default_nettype none

module bmf_window import bmf_pkg::*; (
    input  t_lines           i_lines,
    input  logic [IDX_W-1:0] i_fill,
    input  logic [LAG_W-1:0] i_lag,
    input  t_win_cfg         i_cfg,
    output t_row             o_row
);

    localparam int BASE_W = IDX_W + 1;

    logic [BASE_W-1:0] base;
    t_lines            rows_sel;

    assign base = BASE_W'(i_lag) + BASE_W'(KC);

    // row for each kernel row, background outside the stored part of the frame
    for (genvar gy = 0; gy < MAX_KERNEL; gy++) begin : g_rsel
        localparam logic [BASE_W-1:0] GY = BASE_W'(gy);
        logic [BASE_W-1:0] row_off;
        logic              hit;
        assign row_off = base - GY;
        assign hit     = (base >= GY) && (row_off < BASE_W'(i_fill));
        assign rows_sel[gy] = hit ? i_lines[row_off[IDX_W-1:0]] : '0;
    end

    // column lanes
    for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_lane
        t_taps nbhd;
        for (genvar gy = 0; gy < MAX_KERNEL; gy++) begin : g_ny
            for (genvar gx = 0; gx < MAX_KERNEL; gx++) begin : g_nx
                localparam int SRC = x + gx - KC;
                if (SRC >= 0 && SRC < MAX_WIDTH) begin : g_in
                    assign nbhd[gy][gx] = rows_sel[gy][SRC];
                end else begin : g_out
                    assign nbhd[gy][gx] = 1'b0;
                end
            end
        end

        bmf_lane u_lane (
            .i_nbhd   (nbhd),
            .i_taps   (i_cfg.taps),
            .i_dilate (i_cfg.dilate),
            .i_keep   (i_cfg.keep[x]),
            .o_pix    (o_row[x])
        );
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bmf_line_store.sv =====
// bmf_line_store: shift line store of recent rows with fill and pending counts.
// Depends on bmf_pkg for row and status types.
`default_nettype none

module bmf_line_store import bmf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic        i_push,
    input  t_row        i_push_row,
    input  logic        i_pop,
    output t_lines      o_lines,
    output t_store_stat o_stat
);

    t_lines            r_lines;
    logic [IDX_W-1:0]  r_fill;
    logic [PEND_W-1:0] r_pend;
    logic [IDX_W-1:0]  n_fill;
    logic [PEND_W-1:0] n_pend;

    // newest row at index zero
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_lines <= {r_lines[MAX_KERNEL-2:0], i_push_row};
        end
    end

    // fill saturates at the store depth, pending counts rows not yet filtered
    always_comb begin
        n_fill = r_fill;
        n_pend = r_pend;
        if (i_push && r_fill != IDX_W'(MAX_KERNEL)) begin
            n_fill = r_fill + IDX_W'(1);
        end
        if (i_push && !i_pop) begin
            n_pend = r_pend + PEND_W'(1);
        end else if (!i_push && i_pop) begin
            n_pend = r_pend - PEND_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_fill <= '0;
            r_pend <= '0;
        end else begin
            r_fill <= n_fill;
            r_pend <= n_pend;
        end
    end

    assign o_lines     = r_lines;
    assign o_stat.fill = r_fill;
    assign o_stat.pend = r_pend;

endmodule

`default_nettype wire

// ===== hw/rtl/bmf_out_fifo.sv =====
// bmf_out_fifo: two-entry result queue between the filter and the output port.
// Depends on bmf_pkg for the result type.
`default_nettype none

module bmf_out_fifo import bmf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       rd;

    assign rd      = o_valid && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_space = (r_count != 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_wr && !rd) begin
                r_count <= r_count + 2'd1;
            end else if (!i_wr && rd) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/binary_morphology_filter_unit.sv =====
// binary_morphology_filter_unit: top level of the binary morphology filter.
// Depends on bmf_pkg, bmf_line_store, bmf_window, bmf_out_fifo.
//
//  channel   | direction | signals
//  ----------+-----------+---------------------------------------------------
//  row in    | in        | i_in_valid, o_in_ready, i_row_pixels, i_last_row
//  result    | out       | o_out_valid, i_out_ready, o_out_pixels, o_out_row,
//            |           | o_frame_done
//  config    | in        | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One row beat per cycle in steady state while the output queue has room; a
// result enters the output queue from the input line store after the row that
// completes its window (erode, dilate), or via the middle store too (open, close).
// On the last row the input is held while the window pass flushes: up to kh-1-kh/2+1
// results for one pass, twice that minus one for two, one a cycle given queue room.
// The output queue holds two results, so input keeps flowing while one waits.
// Reset is synchronous, active low; writes to a config register restart the frame.
`default_nettype none

module binary_morphology_filter_unit import bmf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // row input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [63:0]          i_row_pixels,
    input  logic                 i_last_row,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [63:0]          o_out_pixels,
    output logic [15:0]          o_out_row,
    output logic                 o_frame_done,
    // config port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    // config registers
    logic [1:0]           r_op;
    logic                 r_bg;
    logic [6:0]           r_img_w;
    logic [2:0]           r_kw;
    logic [2:0]           r_kh;
    logic [MASK_W-1:0]    r_kmask;
    t_taps                r_taps;

    // frame control
    logic                 r_flush;
    logic [ROW_CNT_W-1:0] r_rows_out;

    logic [2:0]       reg_idx;
    logic             cfg_wr;
    logic             cfg_hit;
    t_row             keep;
    logic [LAG_W-1:0] down;
    logic             two;
    logic             in_acc;
    t_row             in_fg;
    t_lines           in_lines;
    t_lines           mid_lines;
    t_store_stat      in_stat;
    t_store_stat      mid_stat;
    t_win_cfg         cfg_a;
    t_win_cfg         cfg_b;
    t_row             row_a;
    t_row             row_b;
    logic             a_need;
    logic             b_need;
    logic             a_fire;
    logic             b_fire;
    logic             q_space;
    logic             q_wr;
    t_row             q_row;
    logic             q_done;
    logic             frame_end;
    logic             restart;
    t_result          q_in;
    t_result          q_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_hit = cfg_wr && (reg_idx == REG_OPERATION || reg_idx == REG_BACKGROUND
                     || reg_idx == REG_IMAGE_WIDTH || reg_idx == REG_KERNEL_WIDTH
                     || reg_idx == REG_KERNEL_HEIGHT || reg_idx == REG_KERNEL_MASK);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= OP_ERODE;
            r_bg    <= 1'b0;
            r_img_w <= RST_IMAGE_WIDTH;
            r_kw    <= RST_KERNEL_DIM;
            r_kh    <= RST_KERNEL_DIM;
            r_kmask <= RST_KERNEL_MASK;
            r_taps  <= build_taps(RST_KERNEL_DIM, RST_KERNEL_DIM, RST_KERNEL_MASK);
        end else begin
            r_taps <= build_taps(r_kw, r_kh, r_kmask);
            if (cfg_wr) begin
                case (reg_idx)
                    REG_OPERATION:     r_op    <= pwdata[1:0];
                    REG_BACKGROUND:    r_bg    <= pwdata[0];
                    REG_IMAGE_WIDTH:   r_img_w <= pwdata[6:0];
                    REG_KERNEL_WIDTH:  r_kw    <= pwdata[2:0];
                    REG_KERNEL_HEIGHT: r_kh    <= pwdata[2:0];
                    REG_KERNEL_MASK:   r_kmask <= pwdata[MASK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            REG_OPERATION:     prdata = DATA_W'(r_op);
            REG_BACKGROUND:    prdata = DATA_W'(r_bg);
            REG_IMAGE_WIDTH:   prdata = DATA_W'(r_img_w);
            REG_KERNEL_WIDTH:  prdata = DATA_W'(r_kw);
            REG_KERNEL_HEIGHT: prdata = DATA_W'(r_kh);
            REG_KERNEL_MASK:   prdata = DATA_W'(r_kmask);
            default:           prdata = '0;
        endcase
    end

    // derived settings
    assign keep = width_mask(r_img_w);
    assign down = rows_below(r_kh);
    assign two  = (r_op == OP_OPEN) || (r_op == OP_CLOSE);

    assign cfg_a.taps   = r_taps;
    assign cfg_a.keep   = keep;
    assign cfg_a.dilate = (r_op == OP_DILATE) || (r_op == OP_CLOSE);
    assign cfg_b.taps   = r_taps;
    assign cfg_b.keep   = keep;
    assign cfg_b.dilate = (r_op == OP_OPEN);

    // work scheduling: a row is filtered once the rows below it are in,
    // or at once during the flush; second pass waits for the first to finish
    assign a_need = (in_stat.pend > PEND_W'(down)) || (r_flush && in_stat.pend != '0);
    assign b_need = (mid_stat.pend > PEND_W'(down))
                    || (r_flush && in_stat.pend == '0 && mid_stat.pend != '0);
    assign b_fire = two && b_need && q_space;
    assign a_fire = a_need && (two ? (!b_need || b_fire) : q_space);

    assign o_in_ready = !r_flush && !cfg_wr && (!a_need || a_fire);
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_fg      = (r_bg ? ~i_row_pixels : i_row_pixels) & keep;

    // result selection and frame end
    assign q_wr   = two ? b_fire : a_fire;
    assign q_row  = two ? row_b : row_a;
    assign q_done = two ? (r_flush && in_stat.pend == '0 && mid_stat.pend == PEND_W'(1))
                        : (r_flush && in_stat.pend == PEND_W'(1));
    assign frame_end = q_wr && q_done;
    assign restart   = frame_end || cfg_hit;

    assign q_in.pixels = r_bg ? (~q_row & keep) : q_row;
    assign q_in.row    = r_rows_out;
    assign q_in.done   = q_done;

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_flush    <= 1'b0;
            r_rows_out <= '0;
        end else begin
            if (in_acc && i_last_row) begin
                r_flush <= 1'b1;
            end
            if (q_wr) begin
                r_rows_out <= r_rows_out + ROW_CNT_W'(1);
            end
        end
    end

    bmf_line_store u_in_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (restart),
        .i_push     (in_acc),
        .i_push_row (in_fg),
        .i_pop      (a_fire),
        .o_lines    (in_lines),
        .o_stat     (in_stat)
    );

    bmf_window u_win_a (
        .i_lines (in_lines),
        .i_fill  (in_stat.fill),
        .i_lag   (LAG_W'(in_stat.pend - PEND_W'(1))),
        .i_cfg   (cfg_a),
        .o_row   (row_a)
    );

    bmf_line_store u_mid_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (restart),
        .i_push     (a_fire && two),
        .i_push_row (row_a),
        .i_pop      (b_fire),
        .o_lines    (mid_lines),
        .o_stat     (mid_stat)
    );

    bmf_window u_win_b (
        .i_lines (mid_lines),
        .i_fill  (mid_stat.fill),
        .i_lag   (LAG_W'(mid_stat.pend - PEND_W'(1))),
        .i_cfg   (cfg_b),
        .o_row   (row_b)
    );

    bmf_out_fifo u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_in),
        .o_space (q_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (q_out)
    );

    assign o_out_pixels = q_out.pixels;
    assign o_out_row    = q_out.row;
    assign o_frame_done = q_out.done;

`ifndef SYNTHESIS
    // pending rows never outrun the window depth
    a_in_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_stat.pend <= PEND_W'(down) + PEND_W'(1))
        else $error("input line store holds too many pending rows");

    a_mid_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_stat.pend <= PEND_W'(down) + PEND_W'(1))
        else $error("middle line store holds too many pending rows");

    // no new row while the frame is flushing
    a_flush_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> !o_in_ready)
        else $error("input taken during frame flush");

    // queue is never written when full
    a_queue_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr |-> q_space)
        else $error("result written into a full queue");

    // frame end leaves both stores empty
    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_end |=> (in_stat.pend == '0 && mid_stat.pend == '0 && !r_flush))
        else $error("frame state not cleared after last result");
`endif

endmodule

`default_nettype wire
